/* rtl/core/spq_pkg.sv */
// ----------------------------------------------------------------------------
// spq_pkg: shared types for the sorted-insert priority queue
// Operation codes, result status codes and the command bundle that the
// top level broadcasts to every cell of the chain.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int ValueWidth = 32;

  // Operation codes carried by in_op
  typedef enum logic {
    OP_STORE    = 1'b0,
    OP_RETRIEVE = 1'b1
  } op_t;

  // Result status codes carried by out_status
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Command broadcast to all cells together
  typedef struct packed {
    logic                         advance;  // update the chain this cycle
    op_t                          op;       // store or retrieve
    logic signed [ValueWidth-1:0] value;    // value being stored
  } cmd_t;

endpackage

/* rtl/core/spq_cell.sv */
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted chain
// Holds one entry and its occupied flag. On a store it keeps its entry,
// takes the new value, or takes its left neighbor's entry; on a retrieve it
// takes its right neighbor's entry.
// ----------------------------------------------------------------------------
module spq_cell (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  spq_pkg::cmd_t                          cmd,
  input  logic signed [spq_pkg::ValueWidth-1:0]  left_entry,
  input  logic                                   left_occ,
  input  logic                                   left_lt,
  input  logic signed [spq_pkg::ValueWidth-1:0]  right_entry,
  input  logic                                   right_occ,
  output logic signed [spq_pkg::ValueWidth-1:0]  entry,
  output logic                                   occ,
  output logic                                   lt
);

  logic signed [spq_pkg::ValueWidth-1:0] entry_r, entry_nxt;
  logic                                  occ_r, occ_nxt;

  // Flag an occupied entry that is strictly smaller than the incoming value
  assign lt = occ_r && (entry_r < cmd.value);

  // Pick the next entry from self, the new value or a neighbor
  always_comb begin
    entry_nxt = entry_r;
    occ_nxt   = occ_r;
    if (cmd.op == spq_pkg::OP_STORE) begin
      if (!lt) begin
        entry_nxt = left_lt ? cmd.value : left_entry;
      end
      occ_nxt = occ_r | left_occ;
    end else begin
      entry_nxt = right_entry;
      occ_nxt   = right_occ;
    end
  end

  // Clear the occupied flag under reset; update it on advance
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 1'b0;
    end else if (cmd.advance) begin
      occ_r <= occ_nxt;
    end
  end

  // Advance the entry payload
  always_ff @(posedge clk) begin
    if (cmd.advance) begin
      entry_r <= entry_nxt;
    end
  end

  assign entry = entry_r;
  assign occ   = occ_r;

endmodule

/* rtl/core/sorted_insert_priority_queue_unit.sv */
// ----------------------------------------------------------------------------
// sorted_insert_priority_queue_unit: bounded min-first priority queue
// Chain of CAPACITY cells kept in ascending order; one operation per cycle unless stalled.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / in_op / in_value): in_op selects a
//   store of in_value or a retrieve of the smallest entry. Equal values
//   leave newest first, in the reverse of the order they arrived.
//   Result channel (out_valid / out_stall / out_result_value / out_status):
//   exactly one item per accepted input item, in order. A retrieve returns
//   the smallest entry; a store returns 0. Status reports OK, a retrieve on
//   an empty queue (value 0) or a store into a full queue (value dropped).
//   The result is registered and valid in the cycle after acceptance.
//   Throughput: one item per cycle unless the result channel stalls.
//   Every cell compares its entry with the new value in parallel and shifts
//   toward its neighbor in the same cycle, so the chain sets the figure at
//   one operation per clock. A stall on the result channel holds the
//   result register; a new item is accepted only while that register is
//   empty or being drained. Reset clears all occupied flags, leaving the
//   queue empty; entries need no clearing.
// ----------------------------------------------------------------------------
module sorted_insert_priority_queue_unit #(
  parameter int CAPACITY = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic                                   in_op,
  input  logic signed [spq_pkg::ValueWidth-1:0]  in_value,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [spq_pkg::ValueWidth-1:0]  out_result_value,
  output logic [1:0]                             out_status
);

  logic signed [spq_pkg::ValueWidth-1:0] entry_w [CAPACITY];
  logic [CAPACITY-1:0]                   occ_w;
  logic [CAPACITY-1:0]                   lt_w;

  spq_pkg::cmd_t   cmd;
  spq_pkg::op_t    op_w;
  logic            accept;
  logic            is_empty;
  logic            is_full;
  spq_pkg::status_t                      status_nxt;
  logic signed [spq_pkg::ValueWidth-1:0] result_nxt;

  logic                                  out_valid_r;
  spq_pkg::status_t                      status_r;
  logic signed [spq_pkg::ValueWidth-1:0] result_r;

  // Accept while the result register is free or draining
  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  assign op_w     = spq_pkg::op_t'(in_op);
  assign is_empty = !occ_w[0];
  assign is_full  = occ_w[CAPACITY-1];

  // Build the command; drop stores into a full queue and empty retrieves
  always_comb begin
    cmd.op      = op_w;
    cmd.value   = in_value;
    cmd.advance = 1'b0;
    status_nxt  = spq_pkg::ST_OK;
    result_nxt  = '0;
    if (op_w == spq_pkg::OP_STORE) begin
      if (is_full) begin
        status_nxt = spq_pkg::ST_FULL;
      end else begin
        cmd.advance = accept;
      end
    end else begin
      if (is_empty) begin
        status_nxt = spq_pkg::ST_EMPTY;
      end else begin
        cmd.advance = accept;
        result_nxt  = entry_w[0];
      end
    end
  end

  // Chain of cells; the head sees an occupied slot smaller than the new value
  // to its left, the tail sees an empty slot to its right
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [spq_pkg::ValueWidth-1:0] left_entry, right_entry;
    logic                                  left_occ, left_lt, right_occ;

    if (i == 0) begin : g_head
      assign left_entry = '0;
      assign left_occ   = 1'b1;
      assign left_lt    = 1'b1;
    end else begin : g_mid
      assign left_entry = entry_w[i-1];
      assign left_occ   = occ_w[i-1];
      assign left_lt    = lt_w[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_entry = '0;
      assign right_occ   = 1'b0;
    end else begin : g_inner
      assign right_entry = entry_w[i+1];
      assign right_occ   = occ_w[i+1];
    end

    spq_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .cmd         (cmd),
      .left_entry  (left_entry),
      .left_occ    (left_occ),
      .left_lt     (left_lt),
      .right_entry (right_entry),
      .right_occ   (right_occ),
      .entry       (entry_w[i]),
      .occ         (occ_w[i]),
      .lt          (lt_w[i])
    );
  end

  // Hold the result valid flag until the item is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // Load the result payload on acceptance
  always_ff @(posedge clk) begin
    if (accept) begin
      result_r <= result_nxt;
      status_r <= status_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_value = result_r;
  assign out_status       = status_r;

endmodule
